/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: command codes,
// console byte codes and the words that travel between front, queue and back.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // request kinds
   localparam logic [1:0] KIND_PUT  = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_SET  = 2'd2;

   // console byte codes
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   // attribute after reset: white on black
   localparam logic [7:0] ATTR_RESET = 8'h0F;

   // depth of the command queue between front and back
   localparam int CMDQ_DEPTH = 2;

   // decoded commands for the back end
   typedef enum logic [2:0] {
      OP_PUT       = 3'd0,
      OP_NEWLINE   = 3'd1,
      OP_BACKSPACE = 3'd2,
      OP_TAB       = 3'd3,
      OP_READ      = 3'd4,
      OP_SET       = 3'd5,
      OP_NOP       = 3'd6
   } op_type;

   // one classified command word
   typedef struct packed {
      op_type      op;
      logic [7:0]  char_code;  // character to store (space for backspace)
      logic [6:0]  column;     // saturated for set, raw for read
      logic [4:0]  row;
      logic        in_range;   // read target lies inside the screen
   } cmd_type;

   // one result word
   typedef struct packed {
      logic [6:0]  cursor_column_out;
      logic [4:0]  cursor_row_out;
      logic [10:0] cursor_index;
      logic [15:0] cell_value;
      logic        scrolled;
   } rsp_type;

   // back end status toward the request side
   typedef struct packed {
      logic init_busy;  // cell store clearing after reset
   } back_status_type;

endpackage

/* hw/rtl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front
// Request decoder: classifies a console request into a command word and
// clamps set-cursor coordinates to the screen.
// ----------------------------------------------------------------------------
module tcw_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic [1:0]      req_kind,
   input  logic [7:0]      req_char_code,
   input  logic [6:0]      req_cell_column,
   input  logic [4:0]      req_cell_row,
   output tcw_pkg::cmd_type cmd
);
   import tcw_pkg::*;

   logic col_ok;
   logic row_ok;

   // range checks against the screen size
   assign col_ok = 32'(req_cell_column) < COLUMNS;
   assign row_ok = 32'(req_cell_row) < ROWS;

   // classify the request
   always_comb begin
      cmd.op        = OP_NOP;
      cmd.char_code = req_char_code;
      cmd.column    = req_cell_column;
      cmd.row       = req_cell_row;
      cmd.in_range  = col_ok && row_ok;
      unique case (req_kind)
         KIND_PUT: begin
            priority if (req_char_code == CHAR_NEWLINE) begin
               cmd.op = OP_NEWLINE;
            end else if (req_char_code == CHAR_BACKSPACE) begin
               cmd.op        = OP_BACKSPACE;
               cmd.char_code = CHAR_SPACE;
            end else if (req_char_code == CHAR_TAB) begin
               cmd.op = OP_TAB;
            end else begin
               cmd.op = OP_PUT;
            end
         end
         KIND_READ: begin
            cmd.op = OP_READ;
         end
         KIND_SET: begin
            cmd.op = OP_SET;
            if (!col_ok) begin
               cmd.column = 7'(COLUMNS - 1);
            end
            if (!row_ok) begin
               cmd.row = 5'(ROWS - 1);
            end
         end
         default: begin
            cmd.op = OP_NOP;
         end
      endcase
   end

endmodule

/* hw/rtl/tcw_cmd_queue.sv */
// ----------------------------------------------------------------------------
// tcw_cmd_queue
// Short command queue that decouples the request decoder from the back end.
// ----------------------------------------------------------------------------
module tcw_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcw_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output tcw_pkg::cmd_type head_cmd,
   output logic             head_valid
);
   import tcw_pkg::*;

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type            entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = count_ff == CNT_W'(CMDQ_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold command words
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/tcw_back.sv */
// ----------------------------------------------------------------------------
// tcw_back
// Command executor: owns the cursor, the attribute register and the cell
// store. Rows live in a circular buffer, so a scroll rotates the top row
// pointer and blanks the recycled row one cell per cycle.
// ----------------------------------------------------------------------------
module tcw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data,
   input  tcw_pkg::cmd_type         cmd,
   input  logic                     cmd_valid,
   output logic                     cmd_pop,
   output tcw_pkg::rsp_type         rsp,
   output logic                     rsp_valid,
   input  logic                     rsp_pop,
   output tcw_pkg::back_status_type status
);
   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int COL_W  = $clog2(COLUMNS + 1);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_EXEC  = 7'b0000100,
      ST_SWEEP = 7'b0001000,
      ST_WRITE = 7'b0010000,
      ST_READ  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   cmd_type           cmd_ff;
   cmd_type           cmd_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [ROW_W-1:0]  top_ff;
   logic [ROW_W-1:0]  top_in;
   logic [7:0]        attr_ff;
   logic              scrolled_ff;
   logic              scrolled_in;
   logic [15:0]       value_ff;
   logic [15:0]       value_in;
   logic [ADDR_W-1:0] sweep_addr_ff;
   logic [ADDR_W-1:0] sweep_addr_in;
   logic [COL_W-1:0]  sweep_cnt_ff;
   logic [COL_W-1:0]  sweep_cnt_in;
   logic [ADDR_W-1:0] init_addr_ff;
   logic [ADDR_W-1:0] init_addr_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   logic [ROW_W-1:0]  sel_row;
   logic [COL_W-1:0]  sel_col;
   logic [ROW_W:0]    row_sum;
   logic [ROW_W-1:0]  phys_row;
   logic [ADDR_W-1:0] phys_addr;
   logic [COL_W:0]    tab_col;
   logic              wrap;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [15:0]       ram_wdata;
   logic [15:0]       ram_rdata;

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (phys_addr),
      .rd_data (ram_rdata)
   );

   // map a screen row through the rotating top row to a store address
   always_comb begin
      if (state_ff == ST_EXEC) begin
         sel_row = ROW_W'(cmd_ff.row);
         sel_col = COL_W'(cmd_ff.column);
      end else begin
         sel_row = row_ff;
         sel_col = col_ff;
      end
      row_sum   = (ROW_W + 1)'(top_ff) + (ROW_W + 1)'(sel_row);
      phys_row  = (32'(row_sum) >= ROWS) ? ROW_W'(32'(row_sum) - ROWS) : ROW_W'(row_sum);
      phys_addr = ADDR_W'(32'(phys_row) * COLUMNS + 32'(sel_col));
   end

   // next tab stop
   assign tab_col = {1'b0, col_ff[COL_W-1:2], 2'b00} + (COL_W + 1)'(4);
   assign wrap    = (cmd_ff.op == OP_NEWLINE) || (32'(col_ff) >= COLUMNS);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      top_in        = top_ff;
      scrolled_in   = scrolled_ff;
      value_in      = value_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      init_addr_in  = init_addr_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = phys_addr;
      ram_wdata     = {attr_ff, cmd_ff.char_code};

      unique case (state_ff)
         // blank the whole store after reset
         ST_INIT: begin
            ram_we       = 1'b1;
            ram_waddr    = init_addr_ff;
            ram_wdata    = {ATTR_RESET, CHAR_SPACE};
            init_addr_in = init_addr_ff + 1'b1;
            if (init_addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // take the next command word
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd;
               scrolled_in = 1'b0;
               value_in    = '0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff.op)
               OP_NEWLINE, OP_PUT: begin
                  if (wrap) begin
                     col_in = '0;
                     if (row_ff == ROW_W'(ROWS - 1)) begin
                        // recycle the top row as the new bottom row
                        top_in        = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                        sweep_addr_in = ADDR_W'(32'(top_ff) * COLUMNS);
                        sweep_cnt_in  = '0;
                        scrolled_in   = 1'b1;
                        state_in      = ST_SWEEP;
                     end else begin
                        row_in   = row_ff + 1'b1;
                        state_in = (cmd_ff.op == OP_PUT) ? ST_WRITE : ST_DONE;
                     end
                  end else begin
                     state_in = ST_WRITE;
                  end
               end
               OP_BACKSPACE: begin
                  if (col_ff != '0) begin
                     col_in = col_ff - 1'b1;
                  end
                  state_in = ST_WRITE;
               end
               OP_TAB: begin
                  col_in   = (32'(tab_col) > COLUMNS) ? COL_W'(COLUMNS) : COL_W'(tab_col);
                  state_in = ST_DONE;
               end
               OP_SET: begin
                  col_in   = COL_W'(cmd_ff.column);
                  row_in   = ROW_W'(cmd_ff.row);
                  state_in = ST_DONE;
               end
               OP_READ: begin
                  state_in = cmd_ff.in_range ? ST_READ : ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         // blank the recycled row with the current attribute
         ST_SWEEP: begin
            ram_we        = 1'b1;
            ram_waddr     = sweep_addr_ff;
            ram_wdata     = {attr_ff, CHAR_SPACE};
            sweep_addr_in = sweep_addr_ff + 1'b1;
            sweep_cnt_in  = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == COL_W'(COLUMNS - 1)) begin
               state_in = (cmd_ff.op == OP_PUT) ? ST_WRITE : ST_DONE;
            end
         end
         // store the character at the cursor
         ST_WRITE: begin
            ram_we = 1'b1;
            if (cmd_ff.op == OP_PUT) begin
               col_in = col_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         // capture the cell read issued in ST_EXEC
         ST_READ: begin
            value_in = ram_rdata;
            state_in = ST_DONE;
         end
         // hand the result word to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_in.cursor_column_out = 7'(col_ff);
               rsp_in.cursor_row_out    = 5'(row_ff);
               rsp_in.cursor_index      = 11'(32'(col_ff) + COLUMNS * 32'(row_ff));
               rsp_in.cell_value        = value_ff;
               rsp_in.scrolled          = scrolled_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         init_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         init_addr_ff <= init_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      scrolled_ff   <= scrolled_in;
      value_ff      <= value_in;
      sweep_addr_ff <= sweep_addr_in;
      sweep_cnt_ff  <= sweep_cnt_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp              = rsp_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign status.init_busy = state_ff == ST_INIT;

endmodule

/* hw/rtl/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console of COLUMNS x ROWS cells driven by console bytes: put, read a
// cell, set the cursor. Decoder and executor are split by a command queue.
//
//   channel   handshake          words carried
//   req       req_push/full      kind, char_code, cell_column, cell_row
//   rsp       rsp_pop/empty      cursor column/row/index, cell_value, scrolled
//   csr       csr_wr_en          text attribute byte
//
// A plain put passes the executor states issue, decode, write and result;
// newline, tab and set cursor skip the write, and an in-range read swaps it for a cell read.
// A scroll rotates the top row and blanks the recycled row cell by cell
// through the single write port of the cell store.
// After reset the store is blanked one cell per cycle, with full held high;
// csr writes are taken throughout.
// Requests queue while a result waits in the output register.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_char_code,
   input  logic [6:0]  req_cell_column,
   input  logic [4:0]  req_cell_row,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [6:0]  rsp_cursor_column_out,
   output logic [4:0]  rsp_cursor_row_out,
   output logic [10:0] rsp_cursor_index,
   output logic [15:0] rsp_cell_value,
   output logic        rsp_scrolled,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import tcw_pkg::*;

   cmd_type         front_cmd;
   cmd_type         head_cmd;
   logic            queue_full;
   logic            head_valid;
   logic            head_pop;
   rsp_type         rsp;
   logic            rsp_valid;
   back_status_type status;

   // classify requests
   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_kind        (req_kind),
      .req_char_code   (req_char_code),
      .req_cell_column (req_cell_column),
      .req_cell_row    (req_cell_row),
      .cmd             (front_cmd)
   );

   // hold commands between decoder and executor
   tcw_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push && !req_full),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop        (head_pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid)
   );

   // execute commands against the cell store
   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (head_cmd),
      .cmd_valid   (head_valid),
      .cmd_pop     (head_pop),
      .rsp         (rsp),
      .rsp_valid   (rsp_valid),
      .rsp_pop     (rsp_pop),
      .status      (status)
   );

   assign req_full              = queue_full || status.init_busy;
   assign rsp_empty             = !rsp_valid;
   assign rsp_cursor_column_out = rsp.cursor_column_out;
   assign rsp_cursor_row_out    = rsp.cursor_row_out;
   assign rsp_cursor_index      = rsp.cursor_index;
   assign rsp_cell_value        = rsp.cell_value;
   assign rsp_scrolled          = rsp.scrolled;

endmodule

/* verif/text_console_writer_checker.sv */
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the request, result and csr channels of the text console writer.
// It keeps its own copy of the screen, cursor and attribute, works out the
// result word of every accepted request and compares each popped result
// word against the oldest one still awaited.
// ----------------------------------------------------------------------------
module text_console_writer_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_char_code,
   input  logic [6:0]  req_cell_column,
   input  logic [4:0]  req_cell_row,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [6:0]  rsp_cursor_column_out,
   input  logic [4:0]  rsp_cursor_row_out,
   input  logic [10:0] rsp_cursor_index,
   input  logic [15:0] rsp_cell_value,
   input  logic        rsp_scrolled,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int          pending,
   output int          failures,
   output int          results_seen,
   output int          scrolls_seen
);

   import tcw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the console state
   logic [15:0] screen [0:COLUMNS*ROWS-1];
   logic [6:0]  cur_col;
   logic [4:0]  cur_row;
   logic [7:0]  attr;

   // result words still owed by the block, oldest first
   rsp_type     awaited_words [$];
   rsp_type     want;

   // store one character with the current attribute, ignoring off-screen cells
   function automatic void store_cell(logic [6:0] col, logic [4:0] row, logic [7:0] ch);
      if (int'(col) < COLUMNS && int'(row) < ROWS) begin
         screen[int'(row) * COLUMNS + int'(col)] = {attr, ch};
      end
   endfunction

   // go to column 0 of the next row, scrolling at the bottom; report the scroll
   function automatic logic advance_line();
      int k;
      cur_col = '0;
      if (int'(cur_row) + 1 >= ROWS) begin
         cur_row = 5'(ROWS - 1);
         for (k = 0; k < (ROWS - 1) * COLUMNS; k++) begin
            screen[k] = screen[k + COLUMNS];
         end
         for (k = (ROWS - 1) * COLUMNS; k < ROWS * COLUMNS; k++) begin
            screen[k] = {attr, CHAR_SPACE};
         end
         return 1'b1;
      end
      cur_row++;
      return 1'b0;
   endfunction

   // apply one request to the shadow state and return its result word
   function automatic rsp_type console_step(logic [1:0] kind, logic [7:0] ch,
                                            logic [6:0] col, logic [4:0] row);
      rsp_type r;
      int      tab_stop;
      r = '0;
      unique case (kind)
         KIND_PUT: begin
            if (ch == CHAR_NEWLINE) begin
               r.scrolled = advance_line();
            end else if (ch == CHAR_BACKSPACE) begin
               // saturate at column 0, blank the cell landed on
               if (cur_col > 0) cur_col--;
               store_cell(cur_col, cur_row, CHAR_SPACE);
            end else if (ch == CHAR_TAB) begin
               tab_stop = (int'(cur_col) / 4 + 1) * 4;
               cur_col = 7'(tab_stop > COLUMNS ? COLUMNS : tab_stop);
            end else begin
               // a cursor parked past the last column wraps first
               if (int'(cur_col) >= COLUMNS) r.scrolled = advance_line();
               store_cell(cur_col, cur_row, ch);
               cur_col++;
            end
         end
         KIND_READ: begin
            if (int'(col) < COLUMNS && int'(row) < ROWS) begin
               r.cell_value = screen[int'(row) * COLUMNS + int'(col)];
            end
         end
         KIND_SET: begin
            cur_col = int'(col) < COLUMNS ? col : 7'(COLUMNS - 1);
            cur_row = int'(row) < ROWS ? row : 5'(ROWS - 1);
         end
         default: begin
         end
      endcase
      r.cursor_column_out = cur_col;
      r.cursor_row_out    = cur_row;
      r.cursor_index      = 11'(int'(cur_col) + COLUMNS * int'(cur_row));
      return r;
   endfunction

   task automatic check_field(input string field, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v) begin
         failures++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < COLUMNS * ROWS; k++) begin
            screen[k] = {ATTR_RESET, CHAR_SPACE};
         end
         cur_col = '0;
         cur_row = '0;
         attr    = ATTR_RESET;
         awaited_words.delete();
      end else begin
         // compare the popped result word with the oldest expectation
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (awaited_words.size() == 0) begin
               failures++;
               $display("%0t ns: result word with none expected, actual col %0d row %0d",
                        $time, rsp_cursor_column_out, rsp_cursor_row_out);
            end else begin
               want = awaited_words.pop_front();
               if (want.scrolled) scrolls_seen++;
               check_field("cursor_column_out", 16'(want.cursor_column_out),
                           16'(rsp_cursor_column_out));
               check_field("cursor_row_out", 16'(want.cursor_row_out),
                           16'(rsp_cursor_row_out));
               check_field("cursor_index", 16'(want.cursor_index), 16'(rsp_cursor_index));
               check_field("cell_value", want.cell_value, rsp_cell_value);
               check_field("scrolled", 16'(want.scrolled), 16'(rsp_scrolled));
            end
         end
         // predict the accepted request word
         if (req_push && !req_full) begin
            awaited_words.push_back(console_step(req_kind, req_char_code,
                                                 req_cell_column, req_cell_row));
         end
         if (csr_wr_en) attr = csr_wr_data;
      end
      pending <= awaited_words.size();
   end

endmodule

/* verif/tb_text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Regression for the text console writer: a directed pass over the console
// codes, cursor limits, wraps and scrolls, then random console traffic under
// several attribute settings with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_text_console_writer_unit;

   import tcw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_IDLE   = 2'd3;
   localparam int         LIMIT       = 10_000_000;
   localparam int         PHASES      = 4;
   localparam int         PHASE_WORDS = 256;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_kind = '0;
   logic [7:0]  req_char_code = '0;
   logic [6:0]  req_cell_column = '0;
   logic [4:0]  req_cell_row = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [6:0]  rsp_cursor_column_out;
   logic [4:0]  rsp_cursor_row_out;
   logic [10:0] rsp_cursor_index;
   logic [15:0] rsp_cell_value;
   logic        rsp_scrolled;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   int          pending;
   int          failures;
   int          results_seen;
   int          scrolls_seen;
   int          cycle_count = 0;
   int          words_sent = 0;
   bit          steady = 1'b0;

   text_console_writer_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_kind              (req_kind),
      .req_char_code         (req_char_code),
      .req_cell_column       (req_cell_column),
      .req_cell_row          (req_cell_row),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_cursor_column_out (rsp_cursor_column_out),
      .rsp_cursor_row_out    (rsp_cursor_row_out),
      .rsp_cursor_index      (rsp_cursor_index),
      .rsp_cell_value        (rsp_cell_value),
      .rsp_scrolled          (rsp_scrolled),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   text_console_writer_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_kind              (req_kind),
      .req_char_code         (req_char_code),
      .req_cell_column       (req_cell_column),
      .req_cell_row          (req_cell_row),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_cursor_column_out (rsp_cursor_column_out),
      .rsp_cursor_row_out    (rsp_cursor_row_out),
      .rsp_cursor_index      (rsp_cursor_index),
      .rsp_cell_value        (rsp_cell_value),
      .rsp_scrolled          (rsp_scrolled),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .pending               (pending),
      .failures              (failures),
      .results_seen          (results_seen),
      .scrolls_seen          (scrolls_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stall the result side now and then, except in the steady stretch
   always @(posedge clock) begin
      rsp_pop <= steady || ($urandom_range(0, 99) >= 7);
   end

   // end a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("timeout after %0d cycles, %0d result words outstanding",
                  cycle_count, pending);
         $display("text_console_writer_unit regression: fail");
         $finish;
      end
   end

   // offer one request word, with a random gap ahead of it, until it is taken
   task automatic send_word(input logic [1:0] kind, input logic [7:0] ch,
                            input logic [6:0] col, input logic [4:0] row);
      while (!steady && $urandom_range(0, 99) < 7) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_kind        <= kind;
      req_char_code   <= ch;
      req_cell_column <= col;
      req_cell_row    <= row;
      do @(posedge clock); while (req_full);
      words_sent++;
   endtask

   // hold the request side until every awaited result word has been popped
   task automatic drain();
      req_push <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // one random word, weighted toward printing so rows fill and scroll often
   task automatic send_random_word();
      int         pick;
      logic [6:0] col;
      logic [4:0] row;
      pick = $urandom_range(0, 99);
      col  = 7'($urandom_range(0, 127));
      row  = 5'($urandom_range(0, 31));
      if (pick < 50) begin
         send_word(KIND_PUT, 8'($urandom_range(0, 255)), col, row);
      end else if (pick < 60) begin
         send_word(KIND_PUT, CHAR_NEWLINE, col, row);
      end else if (pick < 65) begin
         send_word(KIND_PUT, CHAR_BACKSPACE, col, row);
      end else if (pick < 70) begin
         send_word(KIND_PUT, CHAR_TAB, col, row);
      end else if (pick < 84) begin
         // mostly on-screen reads, often near the bottom where scrolls land
         if ($urandom_range(0, 99) < 85) col = 7'($urandom_range(0, 79));
         case ($urandom_range(0, 9))
            0:       row = 5'($urandom_range(0, 31));
            1, 2, 3: row = 5'($urandom_range(20, 24));
            default: row = 5'($urandom_range(0, 24));
         endcase
         send_word(KIND_READ, 8'($urandom_range(0, 255)), col, row);
      end else if (pick < 96) begin
         // park the cursor near the right edge and bottom to provoke wraps
         case ($urandom_range(0, 9))
            0:             col = 7'($urandom_range(0, 127));
            1, 2, 3, 4, 5: col = 7'($urandom_range(60, 79));
            default:       col = 7'($urandom_range(0, 79));
         endcase
         case ($urandom_range(0, 9))
            0:             row = 5'($urandom_range(0, 31));
            1, 2, 3, 4, 5: row = 5'($urandom_range(20, 24));
            default:       row = 5'($urandom_range(0, 24));
         endcase
         send_word(KIND_SET, 8'($urandom_range(0, 255)), col, row);
      end else begin
         send_word(KIND_IDLE, 8'($urandom_range(0, 255)), col, row);
      end
   endtask

   initial begin
      logic [7:0] attr_value;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes, backspace, tab saturation, wrap and scroll
      send_word(KIND_PUT,  8'h41,          7'd0,   5'd0);
      send_word(KIND_PUT,  8'h00,          7'd0,   5'd0);
      send_word(KIND_PUT,  8'hFF,          7'd0,   5'd0);
      send_word(KIND_READ, 8'h00,          7'd0,   5'd0);
      send_word(KIND_READ, 8'h00,          7'd2,   5'd0);
      send_word(KIND_PUT,  CHAR_BACKSPACE, 7'd0,   5'd0);
      send_word(KIND_READ, 8'h00,          7'd2,   5'd0);
      send_word(KIND_SET,  8'h00,          7'd0,   5'd3);
      send_word(KIND_PUT,  CHAR_BACKSPACE, 7'd0,   5'd0);
      send_word(KIND_PUT,  CHAR_TAB,       7'd0,   5'd0);
      send_word(KIND_SET,  8'h00,          7'd78,  5'd2);
      send_word(KIND_PUT,  CHAR_TAB,       7'd0,   5'd0);
      send_word(KIND_PUT,  CHAR_TAB,       7'd0,   5'd0);
      send_word(KIND_PUT,  8'h5A,          7'd0,   5'd0);
      send_word(KIND_SET,  8'h00,          7'd127, 5'd31);
      send_word(KIND_PUT,  8'h78,          7'd0,   5'd0);
      send_word(KIND_PUT,  8'h79,          7'd0,   5'd0);
      send_word(KIND_READ, 8'h00,          7'd79,  5'd23);
      send_word(KIND_PUT,  CHAR_NEWLINE,   7'd0,   5'd0);
      send_word(KIND_READ, 8'h00,          7'd0,   5'd23);
      send_word(KIND_READ, 8'h00,          7'd80,  5'd0);
      send_word(KIND_READ, 8'h00,          7'd0,   5'd25);
      send_word(KIND_READ, 8'hFF,          7'd127, 5'd31);
      send_word(KIND_IDLE, 8'hFF,          7'd127, 5'd31);
      send_word(KIND_SET,  8'h00,          7'd0,   5'd0);

      // random traffic, one attribute setting per phase
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0:       attr_value = 8'hFF;
            1:       attr_value = 8'h00;
            default: attr_value = 8'($urandom_range(1, 254));
         endcase
         csr_wr_en   <= 1'b1;
         csr_wr_data <= attr_value;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         steady = (phase == 1);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_random_word();
            if ($urandom_range(0, 149) == 0) drain();
         end
      end
      steady = 1'b0;

      // let the last words settle, then give the verdict
      drain();
      repeat (100) @(posedge clock);
      $display("Sent %0d console words over %0d attribute settings; %0d results checked.",
               words_sent, PHASES + 1, results_seen);
      $display("Screen scrolled %0d times; wraps, tab and backspace limits exercised.",
               scrolls_seen);
      if (pending != 0) begin
         $display("%0d result words never arrived", pending);
      end
      if (failures == 0 && pending == 0) begin
         $display("text_console_writer_unit regression: pass");
      end else begin
         $display("text_console_writer_unit regression: fail");
      end
      $finish;
   end

endmodule
